// ===== rtl/counting_multiset_table_assert.svh =====
// Assertion macros shared by the counting multiset table RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef COUNTING_MULTISET_TABLE_ASSERT_SVH
`define COUNTING_MULTISET_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CMS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define CMS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/cms_pkg.sv =====
// Types, constants and helper functions of the counting multiset table.
// Depends on nothing; used by every module of the block except cms_ram.
package cms_pkg;

   localparam int ENTRIES      = 16;
   localparam int KEY_BYTES    = 4;
   localparam int COUNT_WIDTH  = 16;
   localparam int IDX_WIDTH    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int MODE_WIDTH   = 2;
   localparam int KEY_WIDTH    = 32;
   localparam int KEY_FIELD_BYTES = KEY_WIDTH / 8;
   localparam int LEN_WIDTH    = 3;
   localparam int OCC_WIDTH    = 16;
   localparam int STATUS_WIDTH = 2;
   localparam int ENTRY_WIDTH  = KEY_WIDTH + LEN_WIDTH + COUNT_WIDTH;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [IDX_WIDTH-1:0]   IDX_LAST  = IDX_WIDTH'(ENTRIES - 1);

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_ADD    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_QUERY  = 2'd2
   } mode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_SATURATED = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [MODE_WIDTH-1:0] mode;
      logic [KEY_WIDTH-1:0]  key;
      logic [LEN_WIDTH-1:0]  key_length;
   } cms_req_type;

   typedef struct packed {
      logic                    found;
      logic [OCC_WIDTH-1:0]    occurrences;
      logic [STATUS_WIDTH-1:0] status;
   } cms_rsp_type;

   typedef struct packed {
      logic [KEY_WIDTH-1:0]   key;
      logic [LEN_WIDTH-1:0]   length;
      logic [COUNT_WIDTH-1:0] count;
   } cms_entry_type;

   typedef struct packed {
      logic start;
      logic take;
   } cms_ctl_type;

   // Keeps only the significant key bytes: the length, limited to KEY_BYTES.
   function automatic logic [KEY_WIDTH-1:0] mask_key(input logic [KEY_WIDTH-1:0] key,
                                                     input logic [LEN_WIDTH-1:0] len);
      logic [KEY_WIDTH-1:0] masked;
      masked = '0;
      for (int b = 0; b < KEY_FIELD_BYTES; b++) begin
         if ((b < KEY_BYTES) && (int'(len) > b)) begin
            masked[b*8 +: 8] = key[b*8 +: 8];
         end
      end
      return masked;
   endfunction

endpackage

// ===== rtl/counting_multiset_table.sv =====
// Counting multiset table top level: request capture and response register.
// Depends on cms_pkg, cms_ctrl and counting_multiset_table_assert.svh.
//
// A table of keys, each kept with a count. A request beat carries a mode
// (add, remove, query), a key and a key length; a key matches a stored
// entry only when both length and significant key bytes are equal.
// Every request returns exactly one response beat with the found flag,
// the count after the request and a status (ok, full, saturated, not found).
// A request is held while the engine reads the entry memory one entry per
// cycle, then the matching or first free entry is written back at most once.
// The block takes one request at a time: req_ready stays low until the
// engine's result has moved into the output register, and rises in the
// same cycle that this response appears there; the scan of the entry
// memory sets how fast requests are served.
// A finished response waits in the output register while the receiver
// stalls, and the next request may already be accepted and scanned; the
// engine holds its result until the output register is free.
// Synchronous reset empties the table (all valid marks cleared at once)
// and drops any request or response in flight.
`include "counting_multiset_table_assert.svh"

module counting_multiset_table
   import cms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  cms_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output cms_rsp_type rsp_payload
);

   logic        busy_ff, busy_in;
   logic        start_ff, start_in;
   cms_req_type req_ff, req_in;
   logic        rsp_valid_ff, rsp_valid_in;
   cms_rsp_type rsp_ff, rsp_in;

   cms_ctl_type ctl;
   logic        eng_done;
   cms_rsp_type eng_result;
   logic        req_fire;

   assign req_ready = !busy_ff;
   assign req_fire  = req_valid && req_ready;
   assign ctl.start = start_ff;
   assign ctl.take  = eng_done && (!rsp_valid_ff || rsp_ready);

   cms_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .req   (req_ff),
      .ctl   (ctl),
      .done  (eng_done),
      .result(eng_result)
   );

   always_comb begin
      busy_in      = busy_ff;
      start_in     = req_fire;
      req_in       = req_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (req_fire) begin
         busy_in = 1'b1;
         req_in  = req_payload;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl.take) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_in       = eng_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `CMS_ASSERT_NOW(a_take_needs_request, clock, reset, ctl.take, busy_ff && !start_ff)
   `CMS_ASSERT_NEXT(a_fire_starts_engine, clock, reset, req_fire, start_ff && busy_ff)
   `CMS_ASSERT_NOW(a_start_only_when_busy, clock, reset, start_ff, busy_ff && !eng_done)

endmodule

// ===== rtl/cms_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module cms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cms_ctrl.sv =====
// Scan and update engine: owns the entry memory and the valid bits.
// Depends on cms_pkg, cms_ram and counting_multiset_table_assert.svh.
`include "counting_multiset_table_assert.svh"

module cms_ctrl
   import cms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cms_req_type req,
   input  cms_ctl_type ctl,
   output logic        done,
   output cms_rsp_type result
);

   typedef enum logic [2:0] {
      IDLE,
      SCAN,
      LAST_CMP,
      UPDATE,
      RESULT
   } state_type;

   state_type              state_ff, state_in;
   logic [IDX_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   cmp_valid_ff, cmp_valid_in;
   logic [IDX_WIDTH-1:0]   cmp_idx_ff, cmp_idx_in;
   logic                   hit_ff, hit_in;
   logic [IDX_WIDTH-1:0]   hit_idx_ff, hit_idx_in;
   logic [COUNT_WIDTH-1:0] hit_count_ff, hit_count_in;
   logic                   free_ok_ff, free_ok_in;
   logic [IDX_WIDTH-1:0]   free_idx_ff, free_idx_in;
   logic [ENTRIES-1:0]     valid_ff, valid_in;
   cms_rsp_type            result_ff, result_in;

   logic                   ram_wr_en;
   logic [IDX_WIDTH-1:0]   ram_wr_addr;
   cms_entry_type          ram_wr_entry;
   logic                   ram_rd_en;
   logic [ENTRY_WIDTH-1:0] ram_rd_data;
   cms_entry_type          rd_entry;
   logic [KEY_WIDTH-1:0]   req_key;
   logic                   match;
   logic [COUNT_WIDTH-1:0] new_count;

   cms_ram #(
      .WIDTH(ENTRY_WIDTH),
      .DEPTH(ENTRIES)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_entry),
      .rd_en  (ram_rd_en),
      .rd_addr(cnt_ff),
      .rd_data(ram_rd_data)
   );

   assign req_key  = mask_key(req.key, req.key_length);
   assign rd_entry = cms_entry_type'(ram_rd_data);
   assign match    = valid_ff[cmp_idx_ff] && (rd_entry.length == req.key_length) &&
                     (rd_entry.key == req_key);
   assign ram_rd_en = (state_ff == SCAN);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cnt_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_count_in = hit_count_ff;
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;
      valid_in     = valid_ff;
      result_in    = result_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = hit_idx_ff;
      new_count    = hit_count_ff;
      ram_wr_entry.key    = req_key;
      ram_wr_entry.length = req.key_length;
      ram_wr_entry.count  = hit_count_ff;

      if (cmp_valid_ff) begin
         if (match && !hit_ff) begin
            hit_in       = 1'b1;
            hit_idx_in   = cmp_idx_ff;
            hit_count_in = rd_entry.count;
         end
         if (!valid_ff[cmp_idx_ff] && !free_ok_ff) begin
            free_ok_in  = 1'b1;
            free_idx_in = cmp_idx_ff;
         end
      end

      case (state_ff)
         IDLE: begin
            if (ctl.start) begin
               state_in   = SCAN;
               cnt_in     = '0;
               hit_in     = 1'b0;
               free_ok_in = 1'b0;
            end
         end
         SCAN: begin
            cmp_valid_in = 1'b1;
            if (cnt_ff == IDX_LAST) begin
               state_in = LAST_CMP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         LAST_CMP: begin
            state_in = UPDATE;
         end
         UPDATE: begin
            state_in              = RESULT;
            result_in.found       = hit_ff;
            result_in.occurrences = '0;
            result_in.status      = STATUS_OK;
            case (req.mode)
               MODE_ADD: begin
                  if (hit_ff) begin
                     if (hit_count_ff == COUNT_MAX) begin
                        result_in.status      = STATUS_SATURATED;
                        result_in.occurrences = OCC_WIDTH'(hit_count_ff);
                     end else begin
                        new_count             = COUNT_WIDTH'(hit_count_ff + 1'b1);
                        ram_wr_en             = 1'b1;
                        ram_wr_entry.count    = new_count;
                        result_in.occurrences = OCC_WIDTH'(new_count);
                     end
                  end else if (free_ok_ff) begin
                     ram_wr_en             = 1'b1;
                     ram_wr_addr           = free_idx_ff;
                     ram_wr_entry.count    = COUNT_WIDTH'(1);
                     valid_in[free_idx_ff] = 1'b1;
                     result_in.occurrences = OCC_WIDTH'(1);
                  end else begin
                     result_in.status = STATUS_FULL;
                  end
               end
               MODE_REMOVE: begin
                  if (hit_ff) begin
                     if (hit_count_ff != '0) begin
                        new_count = hit_count_ff - 1'b1;
                     end
                     if (new_count == '0) begin
                        valid_in[hit_idx_ff] = 1'b0;
                     end
                     ram_wr_en             = 1'b1;
                     ram_wr_entry.count    = new_count;
                     result_in.occurrences = OCC_WIDTH'(new_count);
                  end else begin
                     result_in.status = STATUS_NOT_FOUND;
                  end
               end
               default: begin
                  if (hit_ff) begin
                     result_in.occurrences = OCC_WIDTH'(hit_count_ff);
                  end
               end
            endcase
         end
         RESULT: begin
            if (ctl.take) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         cmp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         free_ok_ff   <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         cmp_valid_ff <= cmp_valid_in;
         hit_ff       <= hit_in;
         free_ok_ff   <= free_ok_in;
         valid_ff     <= valid_in;
      end
      cnt_ff       <= cnt_in;
      cmp_idx_ff   <= cmp_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_count_ff <= hit_count_in;
      free_idx_ff  <= free_idx_in;
      result_ff    <= result_in;
   end

   assign done   = (state_ff == RESULT);
   assign result = result_ff;

   `CMS_ASSERT_NEXT(a_valid_only_on_update, clock, reset, state_ff != UPDATE, $stable(valid_ff))
   `CMS_ASSERT_NOW(a_full_means_no_free, clock, reset, done && (result_ff.status == STATUS_FULL), &valid_ff)
   `CMS_ASSERT_NOW(a_not_found_flag, clock, reset, done && (result_ff.status == STATUS_NOT_FOUND), !result_ff.found)
   `CMS_ASSERT_NOW(a_saturated_at_max, clock, reset, done && (result_ff.status == STATUS_SATURATED), result_ff.occurrences == OCC_WIDTH'(COUNT_MAX))

endmodule

// ===== dv/counting_multiset_table_tb.sv =====
// Self-checking testbench for counting_multiset_table: a shadow copy of the key table predicts
// every response beat, and plain tasks drive requests with bursts, gaps and receiver stalls.
// Depends on cms_pkg and the counting_multiset_table RTL.
module counting_multiset_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cms_pkg::*;

   localparam logic [MODE_WIDTH-1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS  = 750;
   localparam int POOL_SIZE     = ENTRIES + 8;
   localparam int LONG_HOLDOFF  = 500;
   localparam int SETTLE_CYCLES = 2 * (ENTRIES + 5);

   class multiset_shadow;
      logic [KEY_WIDTH-1:0]   slot_key [ENTRIES];
      logic [LEN_WIDTH-1:0]   slot_len [ENTRIES];
      logic [COUNT_WIDTH-1:0] slot_count [ENTRIES];
      bit                     slot_used [ENTRIES];
      cms_rsp_type            awaited_rsp [$];
      int                     mismatches;

      function new();
         foreach (slot_used[i]) begin
            slot_used[i] = 1'b0;
         end
         mismatches = 0;
      endfunction

      function logic [KEY_WIDTH-1:0] significant(logic [KEY_WIDTH-1:0] key,
                                                 logic [LEN_WIDTH-1:0] len);
         int nbytes;
         logic [KEY_WIDTH-1:0] kept;
         nbytes = (int'(len) > KEY_BYTES) ? KEY_BYTES : int'(len);
         kept = '0;
         for (int b = 0; b < nbytes; b++) begin
            kept[b*8 +: 8] = key[b*8 +: 8];
         end
         return kept;
      endfunction

      function void note_request(cms_req_type req);
         logic [KEY_WIDTH-1:0] key;
         int hit;
         int free_slot;
         cms_rsp_type rsp;
         key = significant(req.key, req.key_length);
         hit = -1;
         free_slot = -1;
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot_used[i]) begin
               if (hit < 0 && slot_len[i] == req.key_length && slot_key[i] == key) begin
                  hit = i;
               end
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         rsp.found = (hit >= 0);
         rsp.occurrences = '0;
         rsp.status = STATUS_OK;
         case (req.mode)
            MODE_ADD: begin
               if (hit >= 0) begin
                  if (slot_count[hit] == COUNT_MAX) begin
                     rsp.status = STATUS_SATURATED;
                  end else begin
                     slot_count[hit] = slot_count[hit] + 1'b1;
                  end
                  rsp.occurrences = OCC_WIDTH'(slot_count[hit]);
               end else if (free_slot >= 0) begin
                  slot_used[free_slot] = 1'b1;
                  slot_key[free_slot] = key;
                  slot_len[free_slot] = req.key_length;
                  slot_count[free_slot] = COUNT_WIDTH'(1);
                  rsp.occurrences = OCC_WIDTH'(1);
               end else begin
                  rsp.status = STATUS_FULL;
               end
            end
            MODE_REMOVE: begin
               if (hit >= 0) begin
                  if (slot_count[hit] != '0) begin
                     slot_count[hit] = slot_count[hit] - 1'b1;
                  end
                  if (slot_count[hit] == '0) begin
                     slot_used[hit] = 1'b0;
                  end
                  rsp.occurrences = OCC_WIDTH'(slot_count[hit]);
               end else begin
                  rsp.status = STATUS_NOT_FOUND;
               end
            end
            default: begin
               if (hit >= 0) begin
                  rsp.occurrences = OCC_WIDTH'(slot_count[hit]);
               end
            end
         endcase
         awaited_rsp.push_back(rsp);
      endfunction

      function void check_response(cms_rsp_type got);
         cms_rsp_type want;
         if (awaited_rsp.size() == 0) begin
            $display("%0t: unexpected response beat, expected none, actual found %b occ %0d st %0d",
                     $time, got.found, got.occurrences, got.status);
            mismatches++;
            return;
         end
         want = awaited_rsp.pop_front();
         if (got.found !== want.found) begin
            $display("%0t: found expected %b actual %b", $time, want.found, got.found);
            mismatches++;
         end
         if (got.occurrences !== want.occurrences) begin
            $display("%0t: occurrences expected %0d actual %0d",
                     $time, want.occurrences, got.occurrences);
            mismatches++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return awaited_rsp.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   cms_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   cms_rsp_type rsp_payload;

   multiset_shadow shadow = new();

   int holdoff_asks = 0;

   logic [KEY_WIDTH-1:0] pool_key [POOL_SIZE];
   logic [LEN_WIDTH-1:0] pool_len [POOL_SIZE];

   counting_multiset_table DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #4 clock = ~clock;

   task automatic issue(input logic [MODE_WIDTH-1:0] mode, input logic [KEY_WIDTH-1:0] key,
                        input logic [LEN_WIDTH-1:0] len);
      cms_req_type req;
      req.mode = mode;
      req.key = key;
      req.key_length = len;
      req_valid <= 1'b1;
      req_payload <= req;
      do @(posedge clock); while (!req_ready);
      shadow.note_request(req);
   endtask

   task automatic pause(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (shadow.outstanding() != 0) @(posedge clock);
   endtask

   task automatic issue_random();
      int r;
      int p;
      int nbytes;
      logic [MODE_WIDTH-1:0] mode;
      logic [KEY_WIDTH-1:0] key;
      logic [LEN_WIDTH-1:0] len;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         mode = MODE_ADD;
      end else if (r < 85) begin
         mode = MODE_REMOVE;
      end else if (r < 95) begin
         mode = MODE_QUERY;
      end else begin
         mode = MODE_UNUSED;
      end
      if ($urandom_range(0, 19) == 0) begin
         key = $urandom;
         len = LEN_WIDTH'($urandom_range(0, 7));
      end else begin
         p = $urandom_range(0, POOL_SIZE - 1);
         len = pool_len[p];
         key = $urandom;
         nbytes = (int'(len) > KEY_BYTES) ? KEY_BYTES : int'(len);
         for (int b = 0; b < nbytes; b++) begin
            key[b*8 +: 8] = pool_key[p][b*8 +: 8];
         end
      end
      issue(mode, key, len);
   endtask

   initial begin
      int run_left;
      bit run_ready;
      int holdoffs_served;
      int hold_left;
      run_left = 0;
      run_ready = 1'b1;
      holdoffs_served = 0;
      hold_left = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            shadow.check_response(rsp_payload);
         end
         if (holdoff_asks != holdoffs_served) begin
            holdoffs_served++;
            hold_left = LONG_HOLDOFF;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (run_left == 0) begin
               run_ready = ($urandom_range(0, 3) != 0);
               run_left = run_ready ? $urandom_range(1, 40) : $urandom_range(1, 20);
            end
            run_left--;
            rsp_ready <= run_ready;
         end
      end
   end

   initial begin
      int burst_left;
      int gap;
      int x;
      logic [7:0] base;
      base = 8'($urandom);
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_key[i] = $urandom;
         pool_key[i][7:0] = 8'(i * 7) + base;
         if (i == POOL_SIZE - 1) begin
            pool_len[i] = '0;
         end else if ($urandom_range(0, 4) == 0) begin
            x = $urandom_range(5, 7);
            pool_len[i] = LEN_WIDTH'(x);
         end else begin
            pool_len[i] = LEN_WIDTH'($urandom_range(1, 4));
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      issue(MODE_QUERY, 32'hFFFF_FFFF, 3'd4);
      issue(MODE_REMOVE, 32'hFFFF_FFFF, 3'd4);
      issue(MODE_ADD, 32'hFFFF_FFFF, 3'd4);
      issue(MODE_ADD, 32'hFFFF_FFFF, 3'd4);
      issue(MODE_ADD, 32'h0000_0000, 3'd4);
      issue(MODE_ADD, 32'h1234_5678, 3'd1);
      issue(MODE_UNUSED, 32'hABCD_EF78, 3'd1);
      issue(MODE_QUERY, 32'h0000_0078, 3'd2);
      issue(MODE_ADD, 32'hDEAD_BEEF, 3'd0);
      issue(MODE_QUERY, 32'h0000_0000, 3'd0);
      issue(MODE_ADD, 32'hCAFE_F00D, 3'd7);
      issue(MODE_QUERY, 32'hCAFE_F00D, 3'd4);
      issue(MODE_QUERY, 32'hCAFE_F00D, 3'd7);
      issue(MODE_REMOVE, 32'hFFFF_FFFF, 3'd4);
      issue(MODE_REMOVE, 32'hFFFF_FFFF, 3'd4);
      issue(MODE_REMOVE, 32'hFFFF_FFFF, 3'd4);
      issue(MODE_REMOVE, 32'h0000_0000, 3'd4);
      issue(MODE_REMOVE, 32'h5555_5578, 3'd1);
      issue(MODE_REMOVE, 32'h0000_0000, 3'd0);
      issue(MODE_REMOVE, 32'hCAFE_F00D, 3'd7);
      drain();

      issue(MODE_ADD, 32'h005A_5A5A, 3'd3);
      issue(MODE_ADD, 32'hC35A_5A5A, 3'd3);
      issue(MODE_QUERY, 32'h005A_5A5A, 3'd3);
      drain();

      for (int i = 0; i < ENTRIES; i++) begin
         issue(MODE_ADD, pool_key[i], pool_len[i]);
      end
      pause(1);

      burst_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 200) begin
            holdoff_asks++;
            burst_left = 40;
         end
         if (n == 450) begin
            drain();
         end
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            pause(gap);
            burst_left = $urandom_range(1, 12);
         end
         issue_random();
         burst_left--;
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cms_pkg.sv
rtl/cms_ram.sv
rtl/cms_ctrl.sv
rtl/counting_multiset_table.sv
dv/counting_multiset_table_tb.sv
